// File: rtl/weighted_vruntime_scheduler_assert.svh
// Assertion macros for the weighted vruntime scheduler.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef WEIGHTED_VRUNTIME_SCHEDULER_ASSERT_SVH
`define WEIGHTED_VRUNTIME_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define WVS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication
`define WVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// File: rtl/wvs_pkg.sv
// Shared types, sizes and the priority-band scale table of the scheduler.
// No dependencies.
`default_nettype none

package wvs_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int KEY_W     = 13;   // 255 * 30 fits
    localparam int SCALE_W   = 5;

    localparam logic [7:0] BAND_W10_MAX = 8'd109;
    localparam logic [7:0] BAND_W8_MAX  = 8'd119;
    localparam logic [7:0] BAND_W6_MAX  = 8'd129;

    // one process table row
    typedef struct packed {
        logic [7:0]  remaining;
        logic [7:0]  burst;
        logic [15:0] pid;
        logic [7:0]  prio;
    } proc_entry_t;

    localparam int ENTRY_W = $bits(proc_entry_t);

    // compare results for one table row against the running best
    typedef struct packed {
        logic             skip;          // finished, not a candidate
        logic             new_min;       // strictly less key, or first candidate
        logic             eq;            // same key as the best so far
        logic             before_first;  // ranks ahead of current tie winner
        logic             before_second; // ranks ahead of current runner-up
        logic [KEY_W-1:0] key;
    } key_cmp_t;

    // 120 / weight for the priority band
    function automatic logic [SCALE_W-1:0] key_scale(input logic [7:0] prio);
        logic [SCALE_W-1:0] s;
        if (prio <= BAND_W10_MAX)
            s = 5'd12;
        else if (prio <= BAND_W8_MAX)
            s = 5'd15;
        else if (prio <= BAND_W6_MAX)
            s = 5'd20;
        else
            s = 5'd30;
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/wvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/wvs_key_unit.sv
// Shared key and ordering compare unit: vruntime key of one row and its rank
// against the running best. Depends on wvs_pkg.
`default_nettype none

module wvs_key_unit (
    input  wire logic                     found,
    input  wire logic [wvs_pkg::KEY_W-1:0] best_key,
    input  wire logic [7:0]               first_prio,
    input  wire logic [7:0]               second_prio,
    input  wire wvs_pkg::proc_entry_t     ent,
    output wvs_pkg::key_cmp_t             cmp
);
    import wvs_pkg::*;

    logic [7:0]         executed;
    logic [SCALE_W-1:0] scale;
    logic [KEY_W-1:0]   key;

    assign executed = ent.burst - ent.remaining;
    assign scale    = key_scale(ent.prio);
    assign key      = {{(KEY_W-8){1'b0}}, executed} * {{(KEY_W-SCALE_W){1'b0}}, scale};

    always_comb
    begin
        cmp.key           = key;
        cmp.skip          = (ent.remaining == 8'd0);
        cmp.new_min       = !found || (key < best_key);
        cmp.eq            = found && (key == best_key);
        // later slot wins a tie only with a strictly better priority
        cmp.before_first  = ent.prio < first_prio;
        cmp.before_second = ent.prio < second_prio;
    end

endmodule

`default_nettype wire

// File: rtl/weighted_vruntime_scheduler.sv
// Weighted vruntime scheduler top level: stream ports, sequencer, process table.
// Depends on wvs_pkg, wvs_ram, wvs_key_unit and weighted_vruntime_scheduler_assert.svh.
`default_nettype none

// A load request is accepted in ST_IDLE; ST_LOAD then writes the table row.
// A tick request is accepted in ST_IDLE and then scanned in ST_SCAN:
// the table RAM has one registered read port, so the scan visits one loaded
// slot per cycle through the shared key/compare unit, then ST_COMMIT commits
// the choice and writes back the remaining count. Only one request is worked
// on at a time; the result sits in an output register, and the next request
// is accepted while it waits to be taken. No clearing pass runs after reset.
module weighted_vruntime_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // proc_priority[7:0], proc_pid[23:8], proc_burst[31:24]
    input  wire logic        s_axis_tuser,  // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,  // run_priority[7:0], run_pid[23:8]
    output logic      [1:0]  m_axis_tuser   // slot_valid[0], load_rejected[1]
);
    import wvs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  in_prio_reg, in_prio_next;
    logic [15:0] in_pid_reg, in_pid_next;
    logic [7:0]  in_burst_reg, in_burst_next;

    logic [CNT_W-1:0] entry_count_reg, entry_count_next;
    logic [IDX_W-1:0] last_slot_reg, last_slot_next;
    logic             has_run_reg, has_run_next;

    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] data_idx_reg, data_idx_next;
    logic             data_vld_reg, data_vld_next;

    logic             found_reg, found_next;
    logic [KEY_W-1:0] best_key_reg, best_key_next;
    logic             ties2_reg, ties2_next;   // two or more share the least key
    logic [IDX_W-1:0] first_slot_reg, first_slot_next;
    logic [IDX_W-1:0] second_slot_reg, second_slot_next;
    proc_entry_t      first_ent_reg, first_ent_next;
    proc_entry_t      second_ent_reg, second_ent_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    logic               out_free;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    proc_entry_t        ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    proc_entry_t        row;
    key_cmp_t           cmp;
    logic               use_second;
    logic [IDX_W-1:0]   pick_slot;
    proc_entry_t        pick_ent;

    wvs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign row = proc_entry_t'(ram_rdata);

    wvs_key_unit u_key (
        .found       (found_reg),
        .best_key    (best_key_reg),
        .first_prio  (first_ent_reg.prio),
        .second_prio (second_ent_reg.prio),
        .ent         (row),
        .cmp         (cmp)
    );

    assign out_free   = !m_tvalid_reg || m_axis_tready;
    // step aside only when the tie winner is the slot that ran last
    assign use_second = ties2_reg && has_run_reg && (last_slot_reg == first_slot_reg);
    assign pick_slot  = use_second ? second_slot_reg : first_slot_reg;
    assign pick_ent   = use_second ? second_ent_reg : first_ent_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    always_comb
    begin
        state_next       = state_reg;
        in_prio_next     = in_prio_reg;
        in_pid_next      = in_pid_reg;
        in_burst_next    = in_burst_reg;
        entry_count_next = entry_count_reg;
        last_slot_next   = last_slot_reg;
        has_run_next     = has_run_reg;
        scan_idx_next    = scan_idx_reg;
        data_idx_next    = data_idx_reg;
        data_vld_next    = 1'b0;
        found_next       = found_reg;
        best_key_next    = best_key_reg;
        ties2_next       = ties2_reg;
        first_slot_next  = first_slot_reg;
        second_slot_next = second_slot_reg;
        first_ent_next   = first_ent_reg;
        second_ent_next  = second_ent_reg;
        m_tvalid_next    = out_free ? 1'b0 : m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        ram_we           = 1'b0;
        ram_waddr        = entry_count_reg[IDX_W-1:0];
        ram_wdata        = '{remaining: in_burst_reg, burst: in_burst_reg,
                             pid: in_pid_reg, prio: in_prio_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_prio_next  = s_axis_tdata[7:0];
                    in_pid_next   = s_axis_tdata[23:8];
                    in_burst_next = s_axis_tdata[31:24];
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    ties2_next    = 1'b0;
                    state_next    = s_axis_tuser ? ST_SCAN : ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    if (entry_count_reg >= CNT_W'(MAX_PROCS))
                    begin
                        m_tuser_next = 2'b10;
                    end
                    else
                    begin
                        m_tuser_next     = 2'b00;
                        ram_we           = 1'b1;
                        entry_count_next = entry_count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // read data is registered, so the compare trails the read address
                if (scan_idx_reg != entry_count_reg)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    data_idx_next = scan_idx_reg[IDX_W-1:0];
                    data_vld_next = 1'b1;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end

                if (data_vld_reg && !cmp.skip)
                begin
                    if (cmp.new_min)
                    begin
                        found_next      = 1'b1;
                        best_key_next   = cmp.key;
                        ties2_next      = 1'b0;
                        first_slot_next = data_idx_reg;
                        first_ent_next  = row;
                    end
                    else if (cmp.eq)
                    begin
                        ties2_next = 1'b1;
                        if (cmp.before_first)
                        begin
                            second_slot_next = first_slot_reg;
                            second_ent_next  = first_ent_reg;
                            first_slot_next  = data_idx_reg;
                            first_ent_next   = row;
                        end
                        else if (!ties2_reg || cmp.before_second)
                        begin
                            second_slot_next = data_idx_reg;
                            second_ent_next  = row;
                        end
                    end
                end
            end

            ST_COMMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tuser_next  = 2'b00;
                    if (found_reg)
                    begin
                        m_tdata_next        = {pick_ent.pid, pick_ent.prio};
                        m_tuser_next        = 2'b01;
                        ram_we              = 1'b1;
                        ram_waddr           = pick_slot;
                        ram_wdata           = pick_ent;
                        ram_wdata.remaining = pick_ent.remaining - 8'd1;
                        last_slot_next      = pick_slot;
                        has_run_next        = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            last_slot_reg   <= '0;
            has_run_reg     <= 1'b0;
            scan_idx_reg    <= '0;
            data_vld_reg    <= 1'b0;
            found_reg       <= 1'b0;
            ties2_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            last_slot_reg   <= last_slot_next;
            has_run_reg     <= has_run_next;
            scan_idx_reg    <= scan_idx_next;
            data_vld_reg    <= data_vld_next;
            found_reg       <= found_next;
            ties2_reg       <= ties2_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_prio_reg     <= in_prio_next;
        in_pid_reg      <= in_pid_next;
        in_burst_reg    <= in_burst_next;
        data_idx_reg    <= data_idx_next;
        best_key_reg    <= best_key_next;
        first_slot_reg  <= first_slot_next;
        second_slot_reg <= second_slot_next;
        first_ent_reg   <= first_ent_next;
        second_ent_reg  <= second_ent_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
    end

`include "weighted_vruntime_scheduler_assert.svh"

    `WVS_ASSERT_NOW(a_idle_zero_payload, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 24'd0)
    `WVS_ASSERT_NOW(a_flags_exclusive, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
    `WVS_ASSERT_NOW(a_count_bound, 1'b1, entry_count_reg <= CNT_W'(MAX_PROCS))
    `WVS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

`default_nettype wire

// File: tb/sv/tb_weighted_vruntime_scheduler.sv
// Self-checking testbench for weighted_vruntime_scheduler: directed and random load/tick
// requests, a predictor of the process table and a scoreboard on the result stream.
// Depends on wvs_pkg and the scheduler RTL.
module tb_weighted_vruntime_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         TABLE_SLOTS   = wvs_pkg::MAX_PROCS;
    localparam logic       FUNC_LOAD     = 1'b0;
    localparam logic       FUNC_TICK     = 1'b1;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 25;   // outlasts the longest tick request
    localparam logic [7:0] BAND_PICK [4] = '{8'd100, 8'd115, 8'd120, 8'd135};

    typedef struct packed {
        logic        load_rejected;
        logic [15:0] run_pid;
        logic [7:0]  run_priority;
        logic        slot_valid;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // proc_priority[7:0], proc_pid[23:8], proc_burst[31:24]
    logic        s_axis_tuser = 1'b0; // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // run_priority[7:0], run_pid[23:8]
    logic [1:0]  m_axis_tuser;        // slot_valid[0], load_rejected[1]

    weighted_vruntime_scheduler u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // predictor copy of the process table
    logic [7:0]  proc_prio  [TABLE_SLOTS];
    logic [15:0] proc_pid   [TABLE_SLOTS];
    logic [7:0]  proc_burst [TABLE_SLOTS];
    logic [7:0]  proc_left  [TABLE_SLOTS];
    int          procs_loaded = 0;
    int          prev_slot = 0;
    bit          ran_before = 1'b0;

    sched_result_t expected_runs[$];
    int            errors = 0;
    bit            sender_idle_on = 1'b1;
    bit            receiver_idle_on = 1'b1;
    bit            hold_request = 1'b0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // executed * (120 / weight): exact stand-in for 1024 * executed / weight
    function automatic int vruntime_key(input int slot);
        logic [7:0] executed;
        int         scale;
        executed = proc_burst[slot] - proc_left[slot];
        if (proc_prio[slot] <= 8'd109)
            scale = 12;
        else if (proc_prio[slot] <= 8'd119)
            scale = 15;
        else if (proc_prio[slot] <= 8'd129)
            scale = 20;
        else
            scale = 30;
        return int'(executed) * scale;
    endfunction

    function automatic bit ranks_ahead(input int a, input int b);
        if (proc_prio[a] != proc_prio[b])
            return proc_prio[a] < proc_prio[b];
        return a < b;
    endfunction

    function automatic sched_result_t predict_schedule(input logic func, input logic [7:0] prio,
                                                       input logic [15:0] pid,
                                                       input logic [7:0] burst);
        sched_result_t res;
        bit            found;
        int            best;
        int            first;
        int            second;
        int            ties;
        int            pick;
        res = '0;
        found = 1'b0;
        best = 0;
        first = 0;
        second = 0;
        ties = 0;
        if (func == FUNC_LOAD)
        begin
            if (procs_loaded >= TABLE_SLOTS)
                res.load_rejected = 1'b1;
            else
            begin
                proc_prio[procs_loaded]  = prio;
                proc_pid[procs_loaded]   = pid;
                proc_burst[procs_loaded] = burst;
                proc_left[procs_loaded]  = burst;
                procs_loaded++;
            end
            return res;
        end
        for (int i = 0; i < procs_loaded; i++)
        begin
            if (proc_left[i] != 0 && (!found || vruntime_key(i) < best))
            begin
                best = vruntime_key(i);
                found = 1'b1;
            end
        end
        if (!found)
            return res;
        // tie winner and runner-up among the least-key processes
        for (int i = 0; i < procs_loaded; i++)
        begin
            if (proc_left[i] == 0 || vruntime_key(i) != best)
                continue;
            if (ties == 0)
                first = i;
            else if (ranks_ahead(i, first))
            begin
                second = first;
                first = i;
            end
            else if (ties == 1 || ranks_ahead(i, second))
                second = i;
            ties++;
        end
        pick = first;
        if (ties >= 2 && ran_before && prev_slot == first)
            pick = second;
        proc_left[pick] = proc_left[pick] - 8'd1;
        prev_slot = pick;
        ran_before = 1'b1;
        res.slot_valid = 1'b1;
        res.run_priority = proc_prio[pick];
        res.run_pid = proc_pid[pick];
        return res;
    endfunction

    function automatic void store_expected(input sched_result_t res);
        expected_runs = {expected_runs, res};
    endfunction

    // result side: scoreboard plus tready stalls
    initial
    begin
        int            stall_left;
        int            hold_left;
        sched_result_t actual;
        sched_result_t want;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                actual.slot_valid    = m_axis_tuser[0];
                actual.load_rejected = m_axis_tuser[1];
                actual.run_priority  = m_axis_tdata[7:0];
                actual.run_pid       = m_axis_tdata[23:8];
                if (expected_runs.size() == 0)
                begin
                    $display("%0t: unexpected result valid=%0d prio=%0d pid=%0d rej=%0d", $time,
                             actual.slot_valid, actual.run_priority, actual.run_pid,
                             actual.load_rejected);
                    errors++;
                end
                else
                begin
                    want = expected_runs.pop_front();
                    if (actual !== want)
                    begin
                        $write("%0t: mismatch expected valid=%0d prio=%0d pid=%0d rej=%0d,",
                               $time, want.slot_valid, want.run_priority, want.run_pid,
                               want.load_rejected);
                        $display(" actual valid=%0d prio=%0d pid=%0d rej=%0d",
                                 actual.slot_valid, actual.run_priority,
                                 actual.run_pid, actual.load_rejected);
                        errors++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (receiver_idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // tvalid is left high on return so back-to-back requests need no second write
    task automatic send_request(input logic func, input logic [7:0] prio,
                                input logic [15:0] pid, input logic [7:0] burst);
        int gap;
        if (sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {burst, pid, prio};
        do
            @(posedge clk);
        while (!s_axis_tready);
        store_expected(predict_schedule(func, prio, pid, burst));
    endtask

    task automatic send_tick();
        send_request(FUNC_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic send_random_request(input int load_one_in);
        logic [7:0] prio;
        logic [7:0] burst;
        if ($urandom_range(1, load_one_in) != 1)
        begin
            send_tick();
            return;
        end
        case ($urandom_range(0, 7))
            4, 5:    prio = 8'($urandom_range(100, 139));
            6:       prio = 8'($urandom);
            default: prio = BAND_PICK[$urandom_range(0, 3)];
        endcase
        case ($urandom_range(0, 15))
            0, 1:    burst = 8'd0;
            2:       burst = 8'($urandom);
            default: burst = 8'($urandom_range(1, 16));
        endcase
        send_request(FUNC_LOAD, prio, 16'($urandom), burst);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // empty table, then a zero-burst process that counts as finished at once
    task automatic test_idle_and_zero_burst();
        send_tick();
        send_request(FUNC_LOAD, 8'd100, 16'h0000, 8'd0);
        send_tick();
    endtask

    // equal keys: earliest load wins the tie, and the two processes then alternate
    task automatic test_tie_order();
        send_request(FUNC_LOAD, 8'd139, 16'hFFFF, 8'd3);
        send_request(FUNC_LOAD, 8'd139, 16'h1234, 8'd3);
        repeat (4) send_tick();
    endtask

    // band edges, out-of-range priorities and the largest burst
    task automatic test_priority_bands();
        send_request(FUNC_LOAD, 8'd0,   16'h5A5A, 8'd255);
        send_request(FUNC_LOAD, 8'd255, 16'hA5A5, 8'd255);
        send_request(FUNC_LOAD, 8'd109, 16'($urandom), 8'd2);
        send_request(FUNC_LOAD, 8'd110, 16'($urandom), 8'd2);
        send_request(FUNC_LOAD, 8'd129, 16'($urandom), 8'd1);
        send_request(FUNC_LOAD, 8'd130, 16'($urandom), 8'd1);
        repeat (6) send_tick();
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_random_request(7);
    endtask

    // receiver holds off while requests keep coming, so the input must stall
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        repeat (40) send_random_request(5);
    endtask

    task automatic test_pause_until_drained();
        wait_for_drain();
        repeat (20) send_random_request(4);
    endtask

    task automatic test_full_speed_tail(input int count);
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        repeat (count) send_random_request(6);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_and_zero_burst();
        test_tie_order();
        test_priority_bands();
        test_random_mix(600);
        test_output_backpressure();
        test_pause_until_drained();
        test_random_mix(130);
        test_full_speed_tail(250);
        wait_for_drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/wvs_pkg.sv
rtl/wvs_ram.sv
rtl/wvs_key_unit.sv
rtl/weighted_vruntime_scheduler.sv
tb/sv/tb_weighted_vruntime_scheduler.sv
